### rtl/gps_binary_message_extractor_macros.svh
// Assertion macros shared by the extractor RTL.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef GPS_BINARY_MESSAGE_EXTRACTOR_MACROS_SVH
`define GPS_BINARY_MESSAGE_EXTRACTOR_MACROS_SVH

// Property must hold in the same cycle.
`define GBX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GBX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/gbx_pkg.sv
// ----------------------------------------------------------------------------
// gbx_pkg
// Types and constants for the GPS binary message extractor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gbx_pkg;

  localparam int WinLen    = 22;
  localparam int FillW     = 5;
  localparam int PayMax    = 12;
  localparam int IdxW      = 4;
  localparam int PayFirst  = 4;
  localparam int TimeKeep  = 13;
  localparam int DopKeep   = 14;

  localparam logic [7:0] SyncByte   = 8'h3F;
  localparam logic [7:0] AcByte     = 8'hAC;
  localparam logic [7:0] IdPosition = 8'h04;
  localparam logic [7:0] IdVelocity = 8'h05;
  localparam logic [7:0] IdTime     = 8'h0F;
  localparam logic [7:0] IdDop      = 8'h0B;

  // Last payload index for each message type.
  localparam logic [IdxW-1:0] LastPosVel = IdxW'(11);
  localparam logic [IdxW-1:0] LastTime   = IdxW'(6);
  localparam logic [IdxW-1:0] LastDop    = IdxW'(7);

  typedef enum logic [1:0] {
    KIND_POS  = 2'd0,
    KIND_VEL  = 2'd1,
    KIND_TIME = 2'd2,
    KIND_DOP  = 2'd3
  } msg_kind_e;

  typedef logic [PayMax-1:0][7:0] payload_t;

  // One recognized message handed from the window to the emitter.
  typedef struct packed {
    logic            valid;
    msg_kind_e       kind;
    logic [IdxW-1:0] last_idx;
    payload_t        payload;
  } gbx_msg_t;

endpackage

`default_nettype wire

### rtl/gbx_if.sv
// ----------------------------------------------------------------------------
// gbx_if
// Valid/ready channels for received bytes and extracted payload bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface gbx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface gbx_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] msg_kind;
  logic [7:0] field_byte;
  logic [3:0] byte_index;
  logic       last_byte;

  modport source (output valid, output msg_kind, output field_byte, output byte_index,
                  output last_byte, input ready);
  modport sink   (input valid, input msg_kind, input field_byte, input byte_index,
                  input last_byte, output ready);
endinterface

`default_nettype wire

### rtl/gbx_window.sv
// ----------------------------------------------------------------------------
// gbx_window
// 22-byte receive window: stores bytes, checks sync/AC/ID when full,
// hands out recognized payloads and slides, trims or clears the window.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gbx_window import gbx_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] in_byte_i,
  input  logic       emit_busy_i,
  output logic       in_ready_o,
  output gbx_msg_t   msg_o
);

  typedef enum logic [2:0] {
    ACT_STORE,
    ACT_SLIDE,
    ACT_CLEAR,
    ACT_KEEP_TIME,
    ACT_KEEP_DOP
  } act_e;

  logic [7:0]       win_q [WinLen];
  logic [7:0]       w     [WinLen];
  logic [FillW-1:0] fill_q, fill_d;
  logic             full_hit;
  logic             acc;
  act_e             act;

  assign full_hit   = (fill_q >= FillW'(WinLen - 1));
  // Hold off the completing byte while the previous message still drains.
  assign in_ready_o = !(emit_busy_i && full_hit);
  assign acc        = in_valid_i && in_ready_o;

  // Window as seen with the incoming byte in the last slot.
  always_comb begin
    for (int i = 0; i < WinLen - 1; i++) begin
      w[i] = win_q[i];
    end
    w[WinLen-1] = in_byte_i;
  end

  always_comb begin
    act            = ACT_STORE;
    fill_d         = fill_q;
    msg_o.valid    = 1'b0;
    msg_o.kind     = KIND_POS;
    msg_o.last_idx = LastPosVel;
    for (int k = 0; k < PayMax; k++) begin
      msg_o.payload[k] = w[PayFirst + k];
    end

    if (acc) begin
      if (!full_hit) begin
        fill_d = fill_q + FillW'(1);
      end else if (w[0] != SyncByte || w[1] != SyncByte) begin
        act    = ACT_SLIDE;
        fill_d = FillW'(WinLen - 1);
      end else if (w[3] != AcByte) begin
        act    = ACT_CLEAR;
        fill_d = '0;
      end else begin
        case (w[2])
          IdPosition: begin
            act         = ACT_CLEAR;
            fill_d      = '0;
            msg_o.valid = 1'b1;
          end
          IdVelocity: begin
            act         = ACT_CLEAR;
            fill_d      = '0;
            msg_o.valid = 1'b1;
            msg_o.kind  = KIND_VEL;
          end
          IdTime: begin
            act            = ACT_KEEP_TIME;
            fill_d         = FillW'(WinLen - TimeKeep);
            msg_o.valid    = 1'b1;
            msg_o.kind     = KIND_TIME;
            msg_o.last_idx = LastTime;
          end
          IdDop: begin
            act            = ACT_KEEP_DOP;
            fill_d         = FillW'(WinLen - DopKeep);
            msg_o.valid    = 1'b1;
            msg_o.kind     = KIND_DOP;
            msg_o.last_idx = LastDop;
          end
          default: begin
            act    = ACT_CLEAR;
            fill_d = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  // Window bytes carry no reset; fill_q says which ones hold data.
  always_ff @(posedge clk_i) begin
    if (acc) begin
      case (act)
        ACT_STORE: begin
          win_q[fill_q] <= in_byte_i;
        end
        ACT_SLIDE: begin
          for (int i = 0; i < WinLen - 1; i++) begin
            win_q[i] <= w[i + 1];
          end
        end
        ACT_KEEP_TIME: begin
          for (int i = 0; i < WinLen - TimeKeep; i++) begin
            win_q[i] <= w[TimeKeep + i];
          end
        end
        ACT_KEEP_DOP: begin
          for (int i = 0; i < WinLen - DopKeep; i++) begin
            win_q[i] <= w[DopKeep + i];
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/gbx_emit.sv
// ----------------------------------------------------------------------------
// gbx_emit
// Payload bank and output register: sends a captured message one byte
// per request, in order, with index and last-byte flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "gps_binary_message_extractor_macros.svh"

module gbx_emit import gbx_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  gbx_msg_t msg_i,
  output logic     busy_o,
  gbx_out_if.source res_o
);

  payload_t        bank_q;
  msg_kind_e       kind_q;
  logic [IdxW-1:0] last_idx_q;
  logic [IdxW-1:0] idx_q;
  logic            busy_q;
  logic            load;
  logic            out_acc;
  logic            at_last;

  assign load    = msg_i.valid;
  assign out_acc = res_o.valid && res_o.ready;
  assign at_last = (idx_q == last_idx_q);
  assign busy_o  = busy_q;

  assign res_o.valid      = busy_q;
  assign res_o.msg_kind   = kind_q;
  assign res_o.field_byte = bank_q[idx_q];
  assign res_o.byte_index = idx_q;
  assign res_o.last_byte  = at_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (load) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (out_acc) begin
      if (at_last) begin
        busy_q <= 1'b0;
        idx_q  <= '0;
      end else begin
        idx_q <= idx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      bank_q     <= msg_i.payload;
      kind_q     <= msg_i.kind;
      last_idx_q <= msg_i.last_idx;
    end
  end

  `GBX_ASSERT(a_no_load_while_busy, load |-> !busy_q, "message captured over a busy bank")
  `GBX_ASSERT(a_index_in_range, busy_q |-> (idx_q <= last_idx_q), "byte index past last")
  `GBX_ASSERT_NEXT(a_drain_done, out_acc && at_last && !load, !busy_q, "bank busy after last")
  `GBX_ASSERT_NEXT(a_stall_hold, busy_q && !res_o.ready && !load, $stable(idx_q),
    "index moved without request")

endmodule

`default_nettype wire

### rtl/gps_binary_message_extractor.sv
// ----------------------------------------------------------------------------
// gps_binary_message_extractor
// Collects GPS receiver bytes into a 22-byte window and emits the payload
// bytes of position, velocity, time and DOP messages.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  rx_i     in   valid/ready   rx_byte[7:0]
//  res_o    out  valid/ready   msg_kind[1:0] field_byte[7:0] byte_index[3:0] last_byte
//
// One byte is taken per cycle while rx_i.ready is high; a window completes in the same cycle as its
// last byte, and its payload appears on res_o in the next cycle.
// A message drains at one byte per cycle while res_o.ready is high: 12, 7 or 8 bytes from the bank.
// The byte that completes the next window waits while the bank drains.
// Reset empties the window and the bank; window bytes need no clearing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gps_binary_message_extractor import gbx_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  gbx_in_if.sink    rx_i,
  gbx_out_if.source res_o
);

  gbx_msg_t msg;
  logic     emit_busy;

  gbx_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rx_i.valid),
    .in_byte_i   (rx_i.rx_byte),
    .emit_busy_i (emit_busy),
    .in_ready_o  (rx_i.ready),
    .msg_o       (msg)
  );

  gbx_emit u_emit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .msg_i  (msg),
    .busy_o (emit_busy),
    .res_o  (res_o)
  );

endmodule

`default_nettype wire
